FILE: design/rle_element_encoder_core_assert.svh
// Assertion macros for the run-length element encoder.
// Each macro expects clk and arst_n in scope.
`ifndef RLE_ELEMENT_ENCODER_CORE_ASSERT_SVH
`define RLE_ELEMENT_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication
`define RLE_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define RLE_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rle_pkg.sv
package rle_pkg;

	localparam int MAX_ELT_BYTES = 8;
	localparam int LEN_W = 4;
	localparam int ELT_W = 8 * MAX_ELT_BYTES;

	// Count code layout
	localparam logic [16:0] RUN_LIMIT = 17'd129031;
	localparam logic [16:0] CNT_MID_LO = 17'd254;
	localparam logic [16:0] CNT_LONG_LO = 17'd508;
	localparam logic [16:0] CNT_HUGE_LO = 17'd64516;
	localparam logic [7:0] BYTE_ESC_MID = 8'd255;
	localparam logic [7:0] BYTE_ESC_LONG = 8'd254;
	localparam logic [7:0] BYTE_STOP = 8'd255;
	localparam logic [15:0] DIGIT_BASE = 16'd254;

	// floor(x/254) = ((x>>1) * RECIP) >> RECIP_SHIFT, exact for x < 65536
	localparam logic [15:0] RECIP = 16'd33027;
	localparam int RECIP_SHIFT = 22;
	localparam int PROD_W = 31;

	localparam logic [1:0] KIND_SHORT = 2'd0;
	localparam logic [1:0] KIND_MID = 2'd1;
	localparam logic [1:0] KIND_LONG = 2'd2;
	localparam logic [1:0] KIND_HUGE = 2'd3;

	// Command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Longest byte burst of one command: four count bytes, element, stop code
	localparam int OUT_MAX = 4 + MAX_ELT_BYTES + 2;
	localparam int OUT_CNT_W = $clog2(OUT_MAX + 1);

	typedef struct packed {
		logic [ELT_W-1:0] element;
		logic [15:0] x;
		logic [1:0] kind;
		logic stop;
	} rle_cmd_t;

	typedef struct packed {
		logic w0;
		logic w1;
	} rle_push_t;

	typedef struct packed {
		logic [QCNT_W-1:0] level;
		logic space;
		logic head_valid;
	} rle_qstat_t;

	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] r;
		r = v;
		if (v == '0)
			r = LEN_W'(1);
		else if (v > LEN_W'(MAX_ELT_BYTES))
			r = LEN_W'(MAX_ELT_BYTES);
		return r;
	endfunction

endpackage

FILE: design/rle_queue.sv
module rle_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rle_pkg::rle_push_t   push,
	input  rle_pkg::rle_cmd_t    wr_data0,
	input  rle_pkg::rle_cmd_t    wr_data1,
	input  logic                 pop,
	output rle_pkg::rle_cmd_t    head,
	output rle_pkg::rle_qstat_t  stat
);

	rle_pkg::rle_cmd_t mem_q [rle_pkg::QDEPTH];
	logic [rle_pkg::QPTR_W-1:0] wp_q;
	logic [rle_pkg::QPTR_W-1:0] rp_q;
	logic [rle_pkg::QCNT_W-1:0] level_q;
	logic do_pop;

	assign do_pop = pop && (level_q != '0);
	assign head = mem_q[rp_q];
	assign stat.level = level_q;
	assign stat.head_valid = (level_q != '0);
	assign stat.space = (level_q <= rle_pkg::QCNT_W'(rle_pkg::QDEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			level_q <= '0;
		end else begin
			if (push.w1)
				wp_q <= wp_q + rle_pkg::QPTR_W'(2);
			else if (push.w0)
				wp_q <= wp_q + rle_pkg::QPTR_W'(1);
			if (do_pop)
				rp_q <= rp_q + rle_pkg::QPTR_W'(1);
			level_q <= level_q + rle_pkg::QCNT_W'(push.w0) + rle_pkg::QCNT_W'(push.w1)
				- rle_pkg::QCNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.w0)
			mem_q[wp_q] <= wr_data0;
		if (push.w1)
			mem_q[wp_q + rle_pkg::QPTR_W'(1)] <= wr_data1;
	end

endmodule

FILE: design/rle_front.sv
module rle_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rle_pkg::LEN_W-1:0]     len,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rle_pkg::ELT_W-1:0]     element,
	input  logic                          last,
	input  logic                          space,
	output rle_pkg::rle_push_t            push,
	output rle_pkg::rle_cmd_t             cmd0,
	output rle_pkg::rle_cmd_t             cmd1
);

	logic [rle_pkg::ELT_W-1:0] run_elem_q;
	logic [16:0] run_cnt_q;
	logic run_open_q;

	logic accept;
	logic same;
	logic match;
	logic closes;
	logic [16:0] new_cnt;
	logic [rle_pkg::ELT_W-1:0] new_elem;
	rle_pkg::rle_cmd_t cmd_old;
	rle_pkg::rle_cmd_t cmd_new;

	function automatic rle_pkg::rle_cmd_t make_cmd(input logic [rle_pkg::ELT_W-1:0] e,
		input logic [16:0] n, input logic stop);
		rle_pkg::rle_cmd_t c;
		c.element = e;
		c.stop = stop;
		if (n < rle_pkg::CNT_MID_LO) begin
			c.kind = rle_pkg::KIND_SHORT;
			c.x = n[15:0];
		end else if (n < rle_pkg::CNT_LONG_LO) begin
			c.kind = rle_pkg::KIND_MID;
			c.x = 16'(n - rle_pkg::CNT_MID_LO);
		end else if (n < rle_pkg::CNT_HUGE_LO) begin
			c.kind = rle_pkg::KIND_LONG;
			c.x = n[15:0];
		end else begin
			c.kind = rle_pkg::KIND_HUGE;
			c.x = 16'(n - rle_pkg::CNT_HUGE_LO);
		end
		return c;
	endfunction

	assign accept = in_valid && space;
	assign in_stall = !space;

	// Compare only the bytes inside the current element length
	always_comb begin
		same = 1'b1;
		for (int i = 0; i < rle_pkg::MAX_ELT_BYTES; i++) begin
			if ((rle_pkg::LEN_W'(i) < len) && (element[8*i +: 8] != run_elem_q[8*i +: 8]))
				same = 1'b0;
		end
	end

	assign match = run_open_q && same && (run_cnt_q < rle_pkg::RUN_LIMIT);
	assign closes = run_open_q && !match;
	assign new_cnt = match ? run_cnt_q + 17'd1 : 17'd1;
	assign new_elem = match ? run_elem_q : element;

	assign cmd_old = make_cmd(run_elem_q, run_cnt_q, 1'b0);
	assign cmd_new = make_cmd(new_elem, new_cnt, 1'b1);

	// A closed run goes first; the final run with its stop code follows
	assign cmd0 = closes ? cmd_old : cmd_new;
	assign cmd1 = cmd_new;
	assign push.w0 = accept && (closes || last);
	assign push.w1 = accept && closes && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_elem_q <= '0;
			run_cnt_q <= '0;
			run_open_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				run_elem_q <= '0;
				run_cnt_q <= '0;
				run_open_q <= 1'b0;
			end else begin
				run_elem_q <= new_elem;
				run_cnt_q <= new_cnt;
				run_open_q <= 1'b1;
			end
		end
	end

endmodule

FILE: design/rle_back.sv
module rle_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [rle_pkg::LEN_W-1:0]  len,
	input  rle_pkg::rle_cmd_t          head,
	input  logic                       head_valid,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 out_byte,
	output logic                       out_last
);

	// Prepare stage: command plus reciprocal product
	logic s1_valid_q;
	rle_pkg::rle_cmd_t cmd_s1;
	logic [rle_pkg::PROD_W-1:0] prod_s1;

	// Emitter: byte burst shifted out from position 0
	logic [7:0] buf_q [rle_pkg::OUT_MAX];
	logic [rle_pkg::OUT_CNT_W-1:0] rem_q;
	logic stop_q;

	logic take;
	logic load_ok;
	logic load;
	logic s1_free;
	logic [7:0] quo;
	logic [15:0] rem16;
	logic [7:0] code [4];
	logic [2:0] clen;
	logic [rle_pkg::OUT_CNT_W-1:0] total;
	logic [7:0] nbuf [rle_pkg::OUT_MAX];

	assign out_valid = (rem_q != '0);
	assign out_byte = buf_q[0];
	assign out_last = stop_q && (rem_q == rle_pkg::OUT_CNT_W'(1));

	assign take = out_valid && !out_stall;
	assign load_ok = (rem_q == '0) || ((rem_q == rle_pkg::OUT_CNT_W'(1)) && take);
	assign load = load_ok && s1_valid_q;
	assign s1_free = !s1_valid_q || load;
	assign pop = head_valid && s1_free;

	assign quo = prod_s1[rle_pkg::RECIP_SHIFT +: 8];
	assign rem16 = cmd_s1.x - 16'(16'(quo) * rle_pkg::DIGIT_BASE);

	always_comb begin
		code[0] = rle_pkg::BYTE_ESC_LONG;
		code[1] = rle_pkg::BYTE_ESC_LONG;
		code[2] = quo;
		code[3] = rem16[7:0];
		clen = 3'd4;
		unique case (cmd_s1.kind)
			rle_pkg::KIND_SHORT: begin
				code[0] = cmd_s1.x[7:0];
				clen = 3'd1;
			end
			rle_pkg::KIND_MID: begin
				code[0] = rle_pkg::BYTE_ESC_MID;
				code[1] = cmd_s1.x[7:0];
				clen = 3'd2;
			end
			rle_pkg::KIND_LONG: begin
				code[1] = quo;
				code[2] = rem16[7:0];
				clen = 3'd3;
			end
			rle_pkg::KIND_HUGE: begin
				clen = 3'd4;
			end
			default: begin
				clen = 3'd4;
			end
		endcase
	end

	// Lay out count code, element bytes lowest first, then the stop code
	always_comb begin
		logic [3:0] rel;
		rel = '0;
		for (int p = 0; p < rle_pkg::OUT_MAX; p++) begin
			if (4'(p) < {1'b0, clen}) begin
				nbuf[p] = code[p[1:0]];
			end else begin
				rel = 4'(p) - {1'b0, clen};
				if (rel < len)
					nbuf[p] = cmd_s1.element[8*rel[2:0] +: 8];
				else
					nbuf[p] = rle_pkg::BYTE_STOP;
			end
		end
	end

	assign total = rle_pkg::OUT_CNT_W'(clen) + rle_pkg::OUT_CNT_W'(len)
		+ (cmd_s1.stop ? rle_pkg::OUT_CNT_W'(2) : rle_pkg::OUT_CNT_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			rem_q <= '0;
			stop_q <= 1'b0;
		end else begin
			if (pop)
				s1_valid_q <= 1'b1;
			else if (load)
				s1_valid_q <= 1'b0;
			if (load) begin
				rem_q <= total;
				stop_q <= cmd_s1.stop;
			end else if (take) begin
				rem_q <= rem_q - rle_pkg::OUT_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= head;
			prod_s1 <= rle_pkg::PROD_W'(head.x[15:1]) * rle_pkg::PROD_W'(rle_pkg::RECIP);
		end
		if (load) begin
			buf_q <= nbuf;
		end else if (take) begin
			for (int i = 0; i < rle_pkg::OUT_MAX - 1; i++)
				buf_q[i] <= buf_q[i+1];
		end
	end

endmodule

FILE: design/rle_element_encoder_core.sv
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_wr_en             cfg_wr_data (elt_length)
// in        in         in_valid / in_stall   element, last
// out       out        out_valid / out_stall out_byte, out_last
//
// One byte leaves per cycle while out_stall is low; the bytes an item causes are
// none while a run grows, count code plus elt_length bytes when a run closes,
// up to 4 + 8 + 1 + 8 + 2 for a last item that closes a run. The output byte rate limits how fast such items enter.
// Items enter back to back while the four-entry command queue has two free slots.
// The first byte of a burst passes the command queue, the prepare stage and the emitter buffer, each registered.
// Reset sets elt_length to 4 and closes any run; no clearing pass is needed.
`include "rle_element_encoder_core_assert.svh"

module rle_element_encoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rle_pkg::LEN_W-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rle_pkg::ELT_W-1:0]     element,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic                          out_last
);

	logic [rle_pkg::LEN_W-1:0] elt_len_q;
	logic [rle_pkg::LEN_W-1:0] len;
	rle_pkg::rle_push_t push;
	rle_pkg::rle_cmd_t cmd0;
	rle_pkg::rle_cmd_t cmd1;
	rle_pkg::rle_cmd_t head;
	rle_pkg::rle_qstat_t qstat;
	logic pop;
	logic in_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			elt_len_q <= rle_pkg::LEN_W'(4);
		else if (cfg_wr_en)
			elt_len_q <= cfg_wr_data;
	end

	assign len = rle_pkg::eff_len(elt_len_q);
	assign in_acc = in_valid && !in_stall;

	rle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.len      (len),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.element  (element),
		.last     (last),
		.space    (qstat.space),
		.push     (push),
		.cmd0     (cmd0),
		.cmd1     (cmd1)
	);

	rle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data0 (cmd0),
		.wr_data1 (cmd1),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	rle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.len        (len),
		.head       (head),
		.head_valid (qstat.head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.out_last   (out_last)
	);

	`RLE_CHECK(a_queue_bound, 1'b1, qstat.level <= rle_pkg::QCNT_W'(rle_pkg::QDEPTH), "command queue overflow")
	`RLE_CHECK(a_last_pushes, in_acc && last, push.w0, "last item pushed no command")
	`RLE_CHECK(a_pair_push, push.w1, in_acc && last && push.w0, "second push without a closing last item")
	`RLE_CHECK_NEXT(a_last_queued, in_acc && last, qstat.head_valid, "queue empty after last item")

endmodule
